FILE: rtl/core/snqh_pkg.sv
// shared constants, register indexes and the scale mask table of the note quantizer
`timescale 1ns / 1ps

package snqh_pkg;

    localparam int PITCH_W  = 15;
    localparam int NOTE_W   = 9;
    localparam int CONF_W   = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SEMIS    = 12;
    localparam int NUM_SCALES = 13;

    localparam logic [3:0] ROOT_MAX  = 4'd11;
    localparam logic [3:0] SCALE_MAX = 4'd12;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROOT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_LIMIT   = 2'd3;

    localparam logic [CONF_W-1:0] CONF_THRESH_RESET = 8'd102;
    localparam logic [CFG_W-1:0]  HYST_LIMIT_RESET  = 8'd166;

    typedef logic [SEMIS-1:0] scale_mask_t;
    typedef logic signed [NOTE_W-1:0] note_t;

    // bit i set: interval of i semitones above the root is in the scale
    function automatic scale_mask_t scale_mask(input logic [3:0] sel);
        scale_mask_t m;
        case (sel)
            4'd0:    m = 12'hFFF; // chromatic
            4'd1:    m = 12'hAB5; // major
            4'd2:    m = 12'h5AD; // natural minor
            4'd3:    m = 12'h6AD; // dorian
            4'd4:    m = 12'h5AB; // phrygian
            4'd5:    m = 12'hAD5; // lydian
            4'd6:    m = 12'h6B5; // mixolydian
            4'd7:    m = 12'h56B; // locrian
            4'd8:    m = 12'h9AD; // harmonic minor
            4'd9:    m = 12'hAAD; // melodic minor
            4'd10:   m = 12'h295; // pentatonic major
            4'd11:   m = 12'h4A9; // pentatonic minor
            default: m = 12'h4E9; // blues, also any index above the table
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/snqh_snap.sv
// rounds a q7.8 pitch and snaps it to the nearest in-scale note, ties going down
`timescale 1ns / 1ps

module snqh_snap (
    input  logic [snqh_pkg::PITCH_W-1:0] pitch,
    input  logic [3:0]                   key_root,
    input  logic [3:0]                   scale_select,
    output snqh_pkg::note_t              note
);

    logic [15:0]                round_sum;
    logic [7:0]                 rounded;
    logic [15:0]                recip_prod;
    logic [3:0]                 quot;
    logic [7:0]                 quot_x12;
    logic [3:0]                 rem;
    logic [3:0]                 root_sat;
    snqh_pkg::scale_mask_t      mask;
    logic [4:0]                 rel_sum;
    logic [3:0]                 rel0;
    logic signed [4:0]          offset;

    assign round_sum = {1'b0, pitch} + 16'd128;
    assign rounded   = round_sum[15:8];

    // rounded / 12 via reciprocal 171/2048, exact for 0..128
    assign recip_prod = {8'd0, rounded} * 16'd171;
    assign quot       = recip_prod[14:11];
    assign quot_x12   = {4'd0, quot} * 8'd12;
    assign rem        = 4'(rounded - quot_x12);

    assign root_sat = (key_root > snqh_pkg::ROOT_MAX) ? snqh_pkg::ROOT_MAX : key_root;
    assign mask     = snqh_pkg::scale_mask(scale_select);

    // pitch class of the rounded note relative to the root
    assign rel_sum = {1'b0, rem} + 5'd12 - {1'b0, root_sat};
    assign rel0    = (rel_sum >= 5'd12) ? 4'(rel_sum - 5'd12) : rel_sum[3:0];

    always_comb begin
        logic [4:0] up_sum;
        logic [4:0] dn_sum;
        logic [3:0] up_idx;
        logic [3:0] dn_idx;
        offset = 5'sd0;
        // walk from far to near so the nearest hit wins, below before above
        for (int s = snqh_pkg::SEMIS - 1; s >= 0; s--) begin
            up_sum = {1'b0, rel0} + 5'(s);
            dn_sum = {1'b0, rel0} + 5'd12 - 5'(s);
            up_idx = (up_sum >= 5'd12) ? 4'(up_sum - 5'd12) : up_sum[3:0];
            dn_idx = (dn_sum >= 5'd12) ? 4'(dn_sum - 5'd12) : dn_sum[3:0];
            if (mask[up_idx]) begin
                offset = 5'(s);
            end
            if (mask[dn_idx]) begin
                offset = -(5'(s));
            end
        end
    end

    assign note = $signed({1'b0, rounded}) + {{4{offset[4]}}, offset};

endmodule

FILE: rtl/core/scale_note_quantizer_hysteresis.sv
// top level of the scale note quantizer with note-change hysteresis
`timescale 1ns / 1ps

// channel   ports                                            handshake
// input     s_detected_pitch, s_pitch_present, s_confidence  s_valid / s_ready
// result    m_target_valid, m_target_note, m_resnapped       m_valid / m_ready
// config    cfg_wr_en, cfg_index, cfg_wdata                  write on cfg_wr_en
//
// one reading per cycle sustained while m_ready holds; a result passes from the
// input register through the snap and hysteresis logic into the result register
// the held target updates as each reading moves into the result register
// a stalled result holds the result register; one more reading waits in the input register
// reset clears the held target and loads the register defaults

module scale_note_quantizer_hysteresis (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [snqh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [snqh_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [snqh_pkg::PITCH_W-1:0]        s_detected_pitch,
    input  logic                                s_pitch_present,
    input  logic [snqh_pkg::CONF_W-1:0]         s_confidence,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_target_valid,
    output logic signed [snqh_pkg::NOTE_W-1:0]  m_target_note,
    output logic                                m_resnapped
);

    logic [3:0]                     key_root_reg;
    logic [3:0]                     scale_select_reg;
    logic [snqh_pkg::CONF_W-1:0]    conf_thresh_reg;
    logic [snqh_pkg::CFG_W-1:0]     hyst_limit_reg;

    logic                           in_valid_reg;
    logic [snqh_pkg::PITCH_W-1:0]   in_pitch_reg;
    logic                           in_present_reg;
    logic [snqh_pkg::CONF_W-1:0]    in_conf_reg;

    logic                           out_valid_reg;
    logic                           out_target_valid_reg;
    snqh_pkg::note_t                out_target_note_reg;
    logic                           out_resnapped_reg;

    logic                           held_valid_reg;
    logic                           held_valid_next;
    snqh_pkg::note_t                held_note_reg;
    snqh_pkg::note_t                held_note_next;

    logic                           fire;
    logic                           voiced;
    logic signed [17:0]             pitch_dist;
    logic [16:0]                    dist_abs;
    logic                           resnap;
    snqh_pkg::note_t                snapped;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    snqh_snap u_snap (
        .pitch        (in_pitch_reg),
        .key_root     (key_root_reg),
        .scale_select (scale_select_reg),
        .note         (snapped)
    );

    assign voiced   = in_present_reg && (in_conf_reg > conf_thresh_reg);
    // distance in 1/256 semitone between the reading and the held note
    assign pitch_dist = $signed({3'b000, in_pitch_reg})
                      - $signed({held_note_reg[8], held_note_reg, 8'd0});
    assign dist_abs = pitch_dist[17] ? 17'(-pitch_dist) : pitch_dist[16:0];
    assign resnap   = voiced && (!held_valid_reg || (dist_abs > {9'd0, hyst_limit_reg}));

    always_comb begin
        held_valid_next = held_valid_reg;
        held_note_next  = held_note_reg;
        if (!voiced) begin
            held_valid_next = 1'b0;
            held_note_next  = '0;
        end else if (resnap) begin
            held_valid_next = 1'b1;
            held_note_next  = snapped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_root_reg     <= '0;
            scale_select_reg <= '0;
            conf_thresh_reg  <= snqh_pkg::CONF_THRESH_RESET;
            hyst_limit_reg   <= snqh_pkg::HYST_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                snqh_pkg::REG_KEY_ROOT:     key_root_reg     <= cfg_wdata[3:0];
                snqh_pkg::REG_SCALE_SELECT: scale_select_reg <= cfg_wdata[3:0];
                snqh_pkg::REG_CONF_THRESH:  conf_thresh_reg  <= cfg_wdata;
                snqh_pkg::REG_HYST_LIMIT:   hyst_limit_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pitch_reg   <= s_detected_pitch;
            in_present_reg <= s_pitch_present;
            in_conf_reg    <= s_confidence;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            held_note_reg  <= '0;
        end else begin
            if (fire) begin
                out_valid_reg  <= 1'b1;
                held_valid_reg <= held_valid_next;
                held_note_reg  <= held_note_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_target_valid_reg <= held_valid_next;
            out_target_note_reg  <= held_note_next;
            out_resnapped_reg    <= resnap;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_target_valid = out_target_valid_reg;
    assign m_target_note  = out_target_note_reg;
    assign m_resnapped    = out_resnapped_reg;

endmodule

FILE: tb/sv/scale_note_quantizer_hysteresis_tb.sv
// self-checking testbench for the scale note quantizer with note-change hysteresis
`timescale 1ns / 1ps

module scale_note_quantizer_hysteresis_tb;

    localparam int DIRECTED_ROWS   = 23;
    localparam int RANDOM_PHASES   = 16;
    localparam int PHASE_ITEMS     = 86;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int QUIET_LIMIT     = 2000;

    typedef struct packed {
        logic            tgt_valid;
        snqh_pkg::note_t note;
        logic            resnap;
    } quant_result_t;

    // reconfig rows drain the pipeline and write all four registers first
    typedef struct packed {
        logic                           reconfig;
        logic [snqh_pkg::CFG_W-1:0]     root_w;
        logic [snqh_pkg::CFG_W-1:0]     scale_w;
        logic [snqh_pkg::CFG_W-1:0]     thresh_w;
        logic [snqh_pkg::CFG_W-1:0]     hyst_w;
        logic [snqh_pkg::PITCH_W-1:0]   pitch;
        logic                           present;
        logic [snqh_pkg::CONF_W-1:0]    conf;
        logic                           typed;
        quant_result_t                  want;
    } directed_row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [snqh_pkg::CFG_IDX_W-1:0]     cfg_index = snqh_pkg::REG_KEY_ROOT;
    logic [snqh_pkg::CFG_W-1:0]         cfg_wdata = '0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [snqh_pkg::PITCH_W-1:0]       s_detected_pitch = '0;
    logic                               s_pitch_present = 1'b0;
    logic [snqh_pkg::CONF_W-1:0]        s_confidence = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic                               m_target_valid;
    snqh_pkg::note_t                    m_target_note;
    logic                               m_resnapped;

    // predictor copy of the registers and the held target
    logic [3:0]                     root_cfg = 4'd0;
    logic [3:0]                     scale_cfg = 4'd0;
    logic [snqh_pkg::CONF_W-1:0]    thresh_cfg = snqh_pkg::CONF_THRESH_RESET;
    logic [snqh_pkg::CFG_W-1:0]     hyst_cfg = snqh_pkg::HYST_LIMIT_RESET;
    logic                           held_valid_q = 1'b0;
    int                             held_note_q = 0;

    quant_result_t pending_targets [$];
    int            mismatch_count = 0;
    bit            sender_calm = 1'b0;
    bit            recv_calm = 1'b0;
    bit            hold_off_req = 1'b0;

    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // reset settings: chromatic, threshold 102, hysteresis 166
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd0,     1'b1, 8'd255, 1'b1, '{1'b1, 9'sd0, 1'b1}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd32767, 1'b1, 8'd255, 1'b1, '{1'b1, 9'sd128, 1'b1}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd32767, 1'b0, 8'd255, 1'b1, '{1'b0, 9'sd0, 1'b0}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd32767, 1'b1, 8'd102, 1'b1, '{1'b0, 9'sd0, 1'b0}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd32767, 1'b1, 8'd103, 1'b1, '{1'b1, 9'sd128, 1'b1}},
        // hysteresis edges around note 100 and 101
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd25600, 1'b1, 8'd200, 1'b1, '{1'b1, 9'sd100, 1'b1}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd25766, 1'b1, 8'd200, 1'b1, '{1'b1, 9'sd100, 1'b0}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd25767, 1'b1, 8'd200, 1'b1, '{1'b1, 9'sd101, 1'b1}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd25690, 1'b1, 8'd200, 1'b1, '{1'b1, 9'sd101, 1'b0}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd25689, 1'b1, 8'd200, 1'b1, '{1'b1, 9'sd100, 1'b1}},
        // half-up rounding on either side of the half
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd15488, 1'b1, 8'd200, 1'b1, '{1'b1, 9'sd61, 1'b1}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd15488, 1'b0, 8'd0,   1'b1, '{1'b0, 9'sd0, 1'b0}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd15487, 1'b1, 8'd255, 1'b1, '{1'b1, 9'sd60, 1'b1}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd15487, 1'b1, 8'd0,   1'b1, '{1'b0, 9'sd0, 1'b0}},
        // root and scale above range saturate, zero threshold and hysteresis
        '{1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00, 15'd0,     1'b1, 8'd1,   1'b0, '0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd0,     1'b1, 8'd0,   1'b0, '0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd32767, 1'b1, 8'd1,   1'b0, '0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd32766, 1'b1, 8'd1,   1'b0, '0},
        // full threshold never voices, then threshold 254 and the reset threshold and hysteresis
        '{1'b1, 8'h0B, 8'h0D, 8'hFF, 8'hFF, 15'd12800, 1'b1, 8'd255, 1'b0, '0},
        '{1'b1, 8'h05, 8'h01, 8'hFE, 8'hFF, 15'd12928, 1'b1, 8'd255, 1'b0, '0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd13183, 1'b1, 8'd255, 1'b0, '0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 15'd13184, 1'b1, 8'd255, 1'b0, '0},
        '{1'b1, 8'h0C, 8'h07, 8'h66, 8'hA6, 15'd6500,  1'b1, 8'd200, 1'b0, '0}
    };

    scale_note_quantizer_hysteresis dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_detected_pitch (s_detected_pitch),
        .s_pitch_present  (s_pitch_present),
        .s_confidence     (s_confidence),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_target_valid   (m_target_valid),
        .m_target_note    (m_target_note),
        .m_resnapped      (m_resnapped)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // round half up, then search outward for the nearest in-scale note, lower side first
    function automatic int nearest_scale_note(input int pitch);
        int         rounded;
        int         root;
        int         sel;
        int         step;
        int         cand;
        logic [11:0] mask;
        rounded = (pitch + 128) >> 8;
        root = (root_cfg > 4'd11) ? 11 : int'(root_cfg);
        sel = (scale_cfg > 4'd12) ? 12 : int'(scale_cfg);
        case (sel)
            0:       mask = 12'hFFF;
            1:       mask = 12'hAB5;
            2:       mask = 12'h5AD;
            3:       mask = 12'h6AD;
            4:       mask = 12'h5AB;
            5:       mask = 12'hAD5;
            6:       mask = 12'h6B5;
            7:       mask = 12'h56B;
            8:       mask = 12'h9AD;
            9:       mask = 12'hAAD;
            10:      mask = 12'h295;
            11:      mask = 12'h4A9;
            default: mask = 12'h4E9;
        endcase
        if (sel == 0) return rounded;
        for (step = 0; step < snqh_pkg::SEMIS; step++) begin
            cand = rounded - step;
            if (mask[(cand - root + 2 * snqh_pkg::SEMIS) % snqh_pkg::SEMIS]) return cand;
            cand = rounded + step;
            if (step != 0 && mask[(cand - root + 2 * snqh_pkg::SEMIS) % snqh_pkg::SEMIS])
                return cand;
        end
        return rounded;
    endfunction

    // advances the held target by one reading and returns the result it causes
    function automatic quant_result_t quantize_reading(
        input logic [snqh_pkg::PITCH_W-1:0] pitch,
        input logic present,
        input logic [snqh_pkg::CONF_W-1:0] conf);
        quant_result_t r;
        int            pitch_dist;
        r.resnap = 1'b0;
        if (present && conf > thresh_cfg) begin
            if (!held_valid_q) begin
                r.resnap = 1'b1;
            end else begin
                pitch_dist = int'(pitch) - held_note_q * 256;
                if (pitch_dist < 0) pitch_dist = -pitch_dist;
                if (pitch_dist > int'(hyst_cfg)) r.resnap = 1'b1;
            end
            if (r.resnap) begin
                held_note_q = nearest_scale_note(int'(pitch));
                held_valid_q = 1'b1;
            end
        end else begin
            held_valid_q = 1'b0;
            held_note_q = 0;
        end
        r.tgt_valid = held_valid_q;
        r.note = held_note_q[snqh_pkg::NOTE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic cfg_write(input logic [snqh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [snqh_pkg::CFG_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        case (idx)
            snqh_pkg::REG_KEY_ROOT:     root_cfg = d[3:0];
            snqh_pkg::REG_SCALE_SELECT: scale_cfg = d[3:0];
            snqh_pkg::REG_CONF_THRESH:  thresh_cfg = d;
            snqh_pkg::REG_HYST_LIMIT:   hyst_cfg = d;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [snqh_pkg::CFG_W-1:0] root_w,
                                 input logic [snqh_pkg::CFG_W-1:0] scale_w,
                                 input logic [snqh_pkg::CFG_W-1:0] thresh_w,
                                 input logic [snqh_pkg::CFG_W-1:0] hyst_w);
        cfg_write(snqh_pkg::REG_KEY_ROOT, root_w);
        cfg_write(snqh_pkg::REG_SCALE_SELECT, scale_w);
        cfg_write(snqh_pkg::REG_CONF_THRESH, thresh_w);
        cfg_write(snqh_pkg::REG_HYST_LIMIT, hyst_w);
        cfg_wr_en <= 1'b0;
    endtask

    // every reading gives exactly one result, so an empty queue means an idle block
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_targets.size() != 0) @(posedge aclk);
    endtask

    task automatic send_reading(input logic [snqh_pkg::PITCH_W-1:0] pitch, input logic present,
                                input logic [snqh_pkg::CONF_W-1:0] conf, input logic typed,
                                input quant_result_t given);
        int            gap;
        quant_result_t predicted;
        gap = sender_calm ? 0 : int'($urandom_range(0, 8));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_detected_pitch <= pitch;
        s_pitch_present  <= present;
        s_confidence     <= conf;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = quantize_reading(pitch, present, conf);
        pending_targets.push_back(typed ? given : predicted);
    endtask

    initial begin : result_sink
        int            stall;
        quant_result_t want;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = recv_calm ? 0 : int'($urandom_range(0, 8));
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_targets.size() == 0) begin
                report_mismatch("unexpected transaction, target_note", int'(m_target_note), 0);
            end else begin
                want = pending_targets.pop_front();
                if (m_target_valid !== want.tgt_valid)
                    report_mismatch("target_valid", int'(m_target_valid), int'(want.tgt_valid));
                if (m_target_note !== want.note)
                    report_mismatch("target_note", int'(m_target_note), int'($signed(want.note)));
                if (m_resnapped !== want.resnap)
                    report_mismatch("resnapped", int'(m_resnapped), int'(want.resnap));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) quiet = 0;
            else quiet++;
        end
        $display("no transaction for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int                             row;
        int                             phase;
        int                             item;
        int                             kind;
        int                             base;
        int                             span;
        int                             p;
        logic                           pres;
        logic [snqh_pkg::CONF_W-1:0]    c;
        logic [snqh_pkg::CFG_W-1:0]     root_w;
        logic [snqh_pkg::CFG_W-1:0]     thresh_w;
        logic [snqh_pkg::CFG_W-1:0]     hyst_w;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_rows[row].reconfig) begin
                settle_pipeline();
                load_settings(directed_rows[row].root_w, directed_rows[row].scale_w,
                              directed_rows[row].thresh_w, directed_rows[row].hyst_w);
            end
            send_reading(directed_rows[row].pitch, directed_rows[row].present,
                         directed_rows[row].conf, directed_rows[row].typed,
                         directed_rows[row].want);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_pipeline();
            root_w   = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd11 : (phase == 5) ? 8'd15
                                   : 8'($urandom_range(0, 255));
            thresh_w = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd255
                                   : 8'($urandom_range(0, 200));
            hyst_w   = (phase == 0) ? 8'd0 : (phase == 2) ? 8'd255
                                   : 8'($urandom_range(0, 255));
            // low nibble walks every scale index, including the ones past the table
            load_settings(root_w, {4'($urandom_range(0, 15)), 4'(phase)}, thresh_w, hyst_w);
            sender_calm = (phase % 4 == 1) || (phase == 3) || (phase == 10);
            recv_calm   = (phase % 4 == 2) || (phase == 10);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                // long receiver stall while readings keep coming
                if (phase == 3 && item == 10) hold_off_req = 1'b1;
                kind = int'($urandom_range(0, 9));
                if (kind < 7) begin
                    // voiced reading wandering around the hysteresis window
                    base = held_valid_q ? held_note_q : int'($urandom_range(0, 128));
                    span = int'(hyst_cfg) + 64;
                    p = base * 256 + int'($urandom_range(0, 2 * span)) - span;
                    if (p < 0) p = 0;
                    if (p > 32767) p = 32767;
                    pres = 1'b1;
                    c = (thresh_cfg == 8'd255) ? 8'd255
                                               : 8'($urandom_range(int'(thresh_cfg) + 1, 255));
                end else if (kind == 7) begin
                    p = int'($urandom_range(0, 32767));
                    pres = 1'b0;
                    c = 8'($urandom_range(0, 255));
                end else if (kind == 8) begin
                    p = int'($urandom_range(0, 32767));
                    pres = 1'b1;
                    c = 8'($urandom_range(0, int'(thresh_cfg)));
                end else begin
                    p = int'($urandom_range(0, 32767));
                    pres = 1'($urandom_range(0, 1));
                    c = 8'($urandom_range(0, 255));
                end
                send_reading(p[snqh_pkg::PITCH_W-1:0], pres, c, 1'b0, '0);
            end
        end

        sender_calm = 1'b0;
        settle_pipeline();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && pending_targets.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
